@@ rtl/pdms_pkg.sv @@
// ----------------------------------------------------------------------------
// pdms_pkg
// Shared types, constants and helpers for the press duration mode selector.
// ----------------------------------------------------------------------------
package pdms_pkg;

    localparam int COUNT_BITS   = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CMP_W        = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int SHOW_W       = 16;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_SHOW    = 2'd1,
        MODE_HOURS   = 2'd2,
        MODE_MINUTES = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DEBOUNCE     = 3'd0,
        REG_SHOW_MIN     = 3'd1,
        REG_SHOW_MAX     = 3'd2,
        REG_SETUP_MIN    = 3'd3,
        REG_SETUP_MAX    = 3'd4,
        REG_ADVANCE_MIN  = 3'd5,
        REG_ADVANCE_MAX  = 3'd6,
        REG_SHOW_TIMEOUT = 3'd7
    } reg_idx_t;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd10;
    localparam logic [CFG_W-1:0] RST_SHOW_MIN     = 16'd10;
    localparam logic [CFG_W-1:0] RST_SHOW_MAX     = 16'd900;
    localparam logic [CFG_W-1:0] RST_SETUP_MIN    = 16'd1000;
    localparam logic [CFG_W-1:0] RST_SETUP_MAX    = 16'd3000;
    localparam logic [CFG_W-1:0] RST_ADVANCE_MIN  = 16'd10;
    localparam logic [CFG_W-1:0] RST_ADVANCE_MAX  = 16'd500;
    localparam logic [CFG_W-1:0] RST_SHOW_TIMEOUT = 16'd3000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] show_min_ticks;
        logic [CFG_W-1:0] show_max_ticks;
        logic [CFG_W-1:0] setup_min_ticks;
        logic [CFG_W-1:0] setup_max_ticks;
        logic [CFG_W-1:0] advance_min_ticks;
        logic [CFG_W-1:0] advance_max_ticks;
        logic [CFG_W-1:0] show_timeout_ticks;
    } cfg_t;

    function automatic logic in_window(
        input logic [COUNT_BITS-1:0] v,
        input logic [CFG_W-1:0]      lo,
        input logic [CFG_W-1:0]      hi
    );
        logic [CMP_W-1:0] v_ext;
        logic [CMP_W-1:0] lo_ext;
        logic [CMP_W-1:0] hi_ext;
        v_ext  = CMP_W'(v);
        lo_ext = CMP_W'(lo);
        hi_ext = CMP_W'(hi);
        return (lo_ext <= v_ext) && (v_ext <= hi_ext);
    endfunction

endpackage

@@ rtl/pdms_if.sv @@
// ----------------------------------------------------------------------------
// pdms_if
// Valid/ready channels for ticks, mode results and register writes.
// ----------------------------------------------------------------------------
interface pdms_tick_if;
    logic valid;
    logic ready;
    logic held;

    modport source (output valid, output held, input ready);
    modport sink (input valid, input held, output ready);
    modport monitor (input valid, input held, input ready);
endinterface

interface pdms_mode_if
    import pdms_pkg::*;
;
    logic  valid;
    logic  ready;
    mode_t mode;

    modport source (output valid, output mode, input ready);
    modport sink (input valid, input mode, output ready);
    modport monitor (input valid, input mode, input ready);
endinterface

interface pdms_cfg_if
    import pdms_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
    modport monitor (input valid, input index, input data, input ready);
endinterface

@@ rtl/pdms_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// pdms_cfg_regs
// Holds the eight timing registers and takes writes from the config channel.
// ----------------------------------------------------------------------------
module pdms_cfg_regs
    import pdms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pdms_cfg_if.sink     cfg,
    output cfg_t         regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (reg_idx_t'(cfg.index))
                REG_DEBOUNCE:     regs_next.debounce_ticks     = cfg.data;
                REG_SHOW_MIN:     regs_next.show_min_ticks     = cfg.data;
                REG_SHOW_MAX:     regs_next.show_max_ticks     = cfg.data;
                REG_SETUP_MIN:    regs_next.setup_min_ticks    = cfg.data;
                REG_SETUP_MAX:    regs_next.setup_max_ticks    = cfg.data;
                REG_ADVANCE_MIN:  regs_next.advance_min_ticks  = cfg.data;
                REG_ADVANCE_MAX:  regs_next.advance_max_ticks  = cfg.data;
                REG_SHOW_TIMEOUT: regs_next.show_timeout_ticks = cfg.data;
                default:          regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.debounce_ticks     <= RST_DEBOUNCE;
            regs_reg.show_min_ticks     <= RST_SHOW_MIN;
            regs_reg.show_max_ticks     <= RST_SHOW_MAX;
            regs_reg.setup_min_ticks    <= RST_SETUP_MIN;
            regs_reg.setup_max_ticks    <= RST_SETUP_MAX;
            regs_reg.advance_min_ticks  <= RST_ADVANCE_MIN;
            regs_reg.advance_max_ticks  <= RST_ADVANCE_MAX;
            regs_reg.show_timeout_ticks <= RST_SHOW_TIMEOUT;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

@@ rtl/press_duration_mode_selector.sv @@
// ----------------------------------------------------------------------------
// The mode for a tick appears on the result channel in the cycle after
// the tick is accepted. Throughput: one tick per cycle, set by the single
// mode update path; a held result stalls intake only when it is not taken.
// Reset clears the press and timeout counters and puts the mode in idle;
// the timing registers return to their default values.
// ----------------------------------------------------------------------------
// press_duration_mode_selector
// Classifies button presses by length and steps through the display modes.
// ----------------------------------------------------------------------------
module press_duration_mode_selector
    import pdms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pdms_tick_if.sink    tick,
    pdms_mode_if.source  result,
    pdms_cfg_if.sink     cfg
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    cfg_t regs;

    logic [COUNT_BITS-1:0] press_count_reg;
    logic [COUNT_BITS-1:0] press_count_next;
    logic                  seen_press_reg;
    logic                  seen_press_next;
    logic                  seen_release_reg;
    logic                  seen_release_next;
    logic [SHOW_W-1:0]     show_count_reg;
    logic [SHOW_W-1:0]     show_count_next;
    mode_t                 mode_reg;
    mode_t                 mode_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  accept;

    pdms_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Handshake outputs: the result register frees up when it is taken.
    always_comb
    begin
        tick.ready    = !out_valid_reg || result.ready;
        accept        = tick.valid && tick.ready;
        result.valid  = out_valid_reg;
        result.mode   = mode_reg;
        out_valid_next = accept || (out_valid_reg && !result.ready);
    end

    // Next state for one tick.
    always_comb
    begin
        press_count_next  = press_count_reg;
        seen_press_next   = seen_press_reg;
        seen_release_next = seen_release_reg;
        show_count_next   = show_count_reg;
        mode_next         = mode_reg;

        if (accept)
        begin
            if (tick.held)
            begin
                if (press_count_reg != COUNT_MAX)
                begin
                    press_count_next = press_count_reg + 1'b1;
                end
                seen_press_next = 1'b1;
            end
            else if (CMP_W'(press_count_reg) >= CMP_W'(regs.debounce_ticks))
            begin
                seen_release_next = 1'b1;
            end

            if (seen_press_next && seen_release_next)
            begin
                seen_press_next   = 1'b0;
                seen_release_next = 1'b0;
                case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (in_window(press_count_next, regs.show_min_ticks,
                                      regs.show_max_ticks))
                        begin
                            mode_next = MODE_SHOW;
                        end
                        else if (in_window(press_count_next, regs.setup_min_ticks,
                                           regs.setup_max_ticks))
                        begin
                            mode_next = MODE_HOURS;
                        end
                    end
                    MODE_HOURS:
                    begin
                        if (in_window(press_count_next, regs.advance_min_ticks,
                                      regs.advance_max_ticks))
                        begin
                            mode_next = MODE_MINUTES;
                        end
                    end
                    MODE_MINUTES:
                    begin
                        if (in_window(press_count_next, regs.advance_min_ticks,
                                      regs.advance_max_ticks))
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    default: mode_next = mode_reg;
                endcase
                press_count_next = '0;
            end

            // The timeout starts counting in the same tick that enters show mode.
            if (mode_next == MODE_SHOW)
            begin
                show_count_next = show_count_reg + 1'b1;
                if (show_count_next >= regs.show_timeout_ticks)
                begin
                    mode_next       = MODE_IDLE;
                    show_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_count_reg  <= '0;
            seen_press_reg   <= 1'b0;
            seen_release_reg <= 1'b0;
            show_count_reg   <= '0;
            mode_reg         <= MODE_IDLE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            press_count_reg  <= press_count_next;
            seen_press_reg   <= seen_press_next;
            seen_release_reg <= seen_release_next;
            show_count_reg   <= show_count_next;
            mode_reg         <= mode_next;
            out_valid_reg    <= out_valid_next;
        end
    end

endmodule

@@ rtl/pdms_checker.sv @@
// ----------------------------------------------------------------------------
// pdms_checker
// Port-level checks on the mode selector, bound to the top level.
// ----------------------------------------------------------------------------
module pdms_checker
    import pdms_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tick_valid,
    input  logic          tick_ready,
    input  logic          result_valid,
    input  logic          result_ready,
    input  mode_t         result_mode,
    input  logic          cfg_valid,
    input  logic          cfg_ready
);

    // A stalled result keeps its mode until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_mode)))
        else $error("result dropped or changed while stalled");

    // Every accepted tick yields a result in the next cycle.
    a_tick_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && tick_ready) |=> result_valid)
        else $error("accepted tick produced no result");

    // An empty result register never blocks intake.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> tick_ready)
        else $error("tick refused while result register is empty");

    // No result appears without a tick behind it.
    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !(tick_valid && tick_ready)) |=> !result_valid)
        else $error("result shown without an accepted tick");

    // Register writes are always taken.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write stalled");

endmodule

bind press_duration_mode_selector pdms_checker u_pdms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick.valid),
    .tick_ready   (tick.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_mode  (result.mode),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready)
);

@@ verif/press_duration_mode_selector_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// press_duration_mode_selector_tb
// Drives button-level ticks through the selector and checks the mode that it
// returns for each tick. The expected mode comes from a predictor in this
// bench that tracks the press counter, the debounce flags, the show-clock
// timeout and the timing registers. The run has a directed part and random
// press sequences under several idle and stall patterns.
// ----------------------------------------------------------------------------
module press_duration_mode_selector_tb;
    import pdms_pkg::*;

    logic clk;
    logic rst_n;

    pdms_tick_if tick_ch ();
    pdms_mode_if mode_ch ();
    pdms_cfg_if  cfg_ch ();

    press_duration_mode_selector dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (mode_ch),
        .cfg    (cfg_ch)
    );

    // Button levels waiting to be sent, and modes waiting to come back.
    logic  tick_levels[$];
    mode_t predicted_modes[$];

    // Predictor copy of the timing registers and of the selector state.
    logic [CFG_W-1:0]      timing [0:7];
    logic [COUNT_BITS-1:0] press_cnt;
    logic                  pressed;
    logic                  released;
    logic [SHOW_W-1:0]     show_cnt;
    mode_t                 cur_mode;

    int   send_idle_pct;
    int   sink_stall_pct;
    logic hold_ticks;
    int   errors;
    int   ticks_taken;
    int   modes_checked;
    int   reg_writes;
    int   modes_seen [0:3];

    function automatic logic in_span(input logic [COUNT_BITS-1:0] v,
                                     input logic [CFG_W-1:0] lo,
                                     input logic [CFG_W-1:0] hi);
        return (lo <= v) && (v <= hi);
    endfunction

    function automatic mode_t next_mode(input logic held);
        if (held)
        begin
            if (press_cnt != '1)
                press_cnt = press_cnt + 1'b1;
            pressed = 1'b1;
        end
        else if (press_cnt >= timing[REG_DEBOUNCE])
        begin
            released = 1'b1;
        end

        if (pressed && released)
        begin
            pressed  = 1'b0;
            released = 1'b0;
            if (cur_mode == MODE_IDLE &&
                in_span(press_cnt, timing[REG_SHOW_MIN], timing[REG_SHOW_MAX]))
                cur_mode = MODE_SHOW;
            else if (cur_mode == MODE_IDLE &&
                     in_span(press_cnt, timing[REG_SETUP_MIN], timing[REG_SETUP_MAX]))
                cur_mode = MODE_HOURS;
            else if (cur_mode == MODE_HOURS &&
                     in_span(press_cnt, timing[REG_ADVANCE_MIN], timing[REG_ADVANCE_MAX]))
                cur_mode = MODE_MINUTES;
            else if (cur_mode == MODE_MINUTES &&
                     in_span(press_cnt, timing[REG_ADVANCE_MIN], timing[REG_ADVANCE_MAX]))
                cur_mode = MODE_IDLE;
            press_cnt = '0;
        end

        // The timeout runs in the same tick that show clock was entered.
        if (cur_mode == MODE_SHOW)
        begin
            show_cnt = show_cnt + 1'b1;
            if (show_cnt >= timing[REG_SHOW_TIMEOUT])
            begin
                cur_mode = MODE_IDLE;
                show_cnt = '0;
            end
        end
        return cur_mode;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Tick driver.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tick_ch.valid <= 1'b0;
            tick_ch.held  <= 1'b0;
        end
        else if (!tick_ch.valid || tick_ch.ready)
        begin
            if (tick_levels.size() != 0 && !hold_ticks &&
                $urandom_range(99) >= send_idle_pct)
            begin
                tick_ch.valid <= 1'b1;
                tick_ch.held  <= tick_levels.pop_front();
            end
            else
            begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            mode_ch.ready <= 1'b0;
        else
            mode_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Predict on each accepted request, then check each accepted result.
    always @(posedge clk)
    begin
        mode_t want;
        if (rst_n && tick_ch.valid && tick_ch.ready)
        begin
            predicted_modes.push_back(next_mode(tick_ch.held));
            ticks_taken++;
        end
        if (rst_n && mode_ch.valid && mode_ch.ready)
        begin
            if (predicted_modes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected mode result %0d, none expected",
                         $time, mode_ch.mode);
            end
            else
            begin
                want = predicted_modes.pop_front();
                modes_checked++;
                if (mode_ch.mode !== want)
                begin
                    errors++;
                    $display("%0t: mode mismatch, expected %0d, got %0d",
                             $time, want, mode_ch.mode);
                end
                else
                begin
                    modes_seen[want]++;
                end
            end
        end
    end

    task automatic write_timing(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        timing[idx] = val;
        reg_writes++;
    endtask

    // Wait until every request is taken and every mode has come back.
    task automatic drain();
        @(negedge clk);
        while (tick_levels.size() != 0 || tick_ch.valid || predicted_modes.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_upper(input logic [CFG_W-1:0] lo,
                                                    input int span);
        if ($urandom_range(0, 7) == 0)
            return '1;
        return lo + CFG_W'($urandom_range(0, span));
    endfunction

    task automatic randomize_timing(input int phase_no);
        logic [CFG_W-1:0] lo;
        // Phase one forces a zero debounce and a zero timeout.
        write_timing(REG_DEBOUNCE, (phase_no == 1) ? '0 : CFG_W'($urandom_range(0, 4)));
        lo = CFG_W'($urandom_range(0, 6));
        write_timing(REG_SHOW_MIN, lo);
        write_timing(REG_SHOW_MAX, pick_upper(lo, 6));
        lo = CFG_W'($urandom_range(0, 15));
        write_timing(REG_SETUP_MIN, lo);
        write_timing(REG_SETUP_MAX, pick_upper(lo, 10));
        lo = CFG_W'($urandom_range(0, 4));
        write_timing(REG_ADVANCE_MIN, lo);
        write_timing(REG_ADVANCE_MAX, pick_upper(lo, 6));
        write_timing(REG_SHOW_TIMEOUT,
                     (phase_no == 1) ? '0 : CFG_W'($urandom_range(0, 20)));
    endtask

    // Mostly whole presses of random length, with some stray levels mixed in.
    task automatic queue_presses(input int n);
        int added;
        int cap;
        int len;
        int gap;
        added = 0;
        cap = (timing[REG_SETUP_MAX] > 30) ? 30 : int'(timing[REG_SETUP_MAX]);
        while (added < n)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                tick_levels.push_back(1'($urandom_range(0, 1)));
                added++;
            end
            else
            begin
                len = $urandom_range(1, cap + 3);
                gap = $urandom_range(1, 3);
                repeat (len) tick_levels.push_back(1'b1);
                repeat (gap) tick_levels.push_back(1'b0);
                added += len + gap;
            end
        end
    endtask

    initial
    begin
        logic [17:0] walk;
        int          idle_sets  [0:3];
        int          stall_sets [0:3];

        idle_sets  = '{0, 45, 0, 9};
        stall_sets = '{0, 0, 45, 9};
        walk = 18'b10_10_00_11110_110_10_10;

        rst_n          = 1'b0;
        tick_ch.valid  = 1'b0;
        tick_ch.held   = 1'b0;
        mode_ch.ready  = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_DEBOUNCE;
        cfg_ch.data    = '0;
        hold_ticks     = 1'b0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        errors         = 0;
        ticks_taken    = 0;
        modes_checked  = 0;
        reg_writes     = 0;
        modes_seen     = '{0, 0, 0, 0};

        timing[REG_DEBOUNCE]     = RST_DEBOUNCE;
        timing[REG_SHOW_MIN]     = RST_SHOW_MIN;
        timing[REG_SHOW_MAX]     = RST_SHOW_MAX;
        timing[REG_SETUP_MIN]    = RST_SETUP_MIN;
        timing[REG_SETUP_MAX]    = RST_SETUP_MAX;
        timing[REG_ADVANCE_MIN]  = RST_ADVANCE_MIN;
        timing[REG_ADVANCE_MAX]  = RST_ADVANCE_MAX;
        timing[REG_SHOW_TIMEOUT] = RST_SHOW_TIMEOUT;
        press_cnt = '0;
        pressed   = 1'b0;
        released  = 1'b0;
        show_cnt  = '0;
        cur_mode  = MODE_IDLE;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // With the reset timing, a press of eleven ticks enters show clock.
        repeat (11) tick_levels.push_back(1'b1);
        tick_levels.push_back(1'b0);
        drain();

        // Small windows: a glitch that builds up, show clock and its timeout,
        // hour and minute setting, and a short release that does not count.
        write_timing(REG_DEBOUNCE, 16'd2);
        write_timing(REG_SHOW_MIN, 16'd2);
        write_timing(REG_SHOW_MAX, 16'd3);
        write_timing(REG_SETUP_MIN, 16'd4);
        write_timing(REG_SETUP_MAX, 16'd6);
        write_timing(REG_ADVANCE_MIN, 16'd1);
        write_timing(REG_ADVANCE_MAX, 16'd2);
        write_timing(REG_SHOW_TIMEOUT, 16'd3);
        for (int i = 17; i >= 0; i--)
            tick_levels.push_back(walk[i]);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            send_idle_pct  = idle_sets[p % 4];
            sink_stall_pct = stall_sets[p % 4];
            randomize_timing(p);
            queue_presses(170);
            if (p == 5)
            begin
                @(negedge clk);
                while (tick_levels.size() > 90)
                    @(negedge clk);
                @(posedge clk);
                hold_ticks <= 1'b1;
                @(negedge clk);
                while (tick_ch.valid || predicted_modes.size() != 0)
                    @(negedge clk);
                @(posedge clk);
                hold_ticks <= 1'b0;
            end
            drain();
        end

        $display("Covered %0d ticks and %0d mode results over %0d register writes,",
                 ticks_taken, modes_checked, reg_writes);
        $display("under idle and stall mixes; modes idle/show/hours/minutes: %0d/%0d/%0d/%0d.",
                 modes_seen[0], modes_seen[1], modes_seen[2], modes_seen[3]);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
